FILE: rtl/qdec_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature decoder package
// Shared item types, register codes and decode constants of the quadrature
// decoder with acceleration.
// ----------------------------------------------------------------------------
`default_nettype none

package qdec_pkg;

   // Command codes carried in the request item.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // Transition history patterns that complete a detent.
   localparam logic [7:0] PAT_CCW = 8'h2b;
   localparam logic [7:0] PAT_CW  = 8'h17;

   // Bit i is set when pin history code i is a legal quadrature transition.
   localparam logic [15:0] VALID_TRANSITION = 16'h6996;

   // Register defaults after reset.
   localparam logic [15:0] FAST_THRESHOLD_RESET   = 16'd10;
   localparam logic [15:0] MEDIUM_THRESHOLD_RESET = 16'd50;
   localparam logic [3:0]  FAST_GAIN_RESET        = 4'd4;
   localparam logic [3:0]  MEDIUM_GAIN_RESET      = 4'd2;

   localparam logic signed [15:0] TOTAL_MAX = 16'sh7fff;
   localparam logic signed [15:0] TOTAL_MIN = -16'sh8000;

   typedef enum logic [1:0] {
      CSR_FAST_THRESHOLD   = 2'd0,
      CSR_MEDIUM_THRESHOLD = 2'd1,
      CSR_FAST_GAIN        = 2'd2,
      CSR_MEDIUM_GAIN      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        command;
      logic        data_pin;
      logic        clock_pin;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic signed [4:0]  step;
      logic               step_valid;
      logic signed [15:0] rotation_total;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] fast_threshold_ms;
      logic [15:0] medium_threshold_ms;
      logic [3:0]  fast_gain;
      logic [3:0]  medium_gain;
   } cfg_type;

   typedef struct packed {
      logic [3:0]         pin_history;
      logic [7:0]         transition_history;
      logic [31:0]        last_detent_time;
      logic signed [15:0] rotation_accumulator;
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/qdec_stream_if.sv
// ----------------------------------------------------------------------------
// Quadrature decoder stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface qdec_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/qdec_step.sv
// ----------------------------------------------------------------------------
// Quadrature decoder step logic
// Computes the next decoder state and the result item for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_step
   import qdec_pkg::*;
(
   input  wire cfg_type      cfg,
   input  wire state_type    state_cur,
   input  wire req_item_type item,
   output state_type         state_next,
   output rsp_item_type      result
);

   logic [3:0]         pin_next;
   logic               legal;
   logic [7:0]         trans_next;
   logic               detent;
   logic               clockwise;
   logic [31:0]        elapsed;
   logic [3:0]         gain;
   logic signed [4:0]  step;
   logic signed [16:0] sum;
   logic signed [15:0] acc_next;

   always_comb begin
      pin_next   = {state_cur.pin_history[1:0], item.data_pin, item.clock_pin};
      legal      = VALID_TRANSITION[pin_next];
      trans_next = legal ? {state_cur.transition_history[3:0], pin_next}
                         : state_cur.transition_history;
      clockwise  = (trans_next == PAT_CW);
      detent     = legal && (clockwise || trans_next == PAT_CCW);
      elapsed    = item.now_ms - state_cur.last_detent_time;

      priority if (elapsed < {16'd0, cfg.fast_threshold_ms}) begin
         gain = cfg.fast_gain;
      end else if (elapsed < {16'd0, cfg.medium_threshold_ms}) begin
         gain = cfg.medium_gain;
      end else begin
         gain = 4'd1;
      end

      step = clockwise ? $signed({1'b0, gain}) : -$signed({1'b0, gain});

      // The step never exceeds 15 in magnitude, so one bit of growth is enough.
      sum = {state_cur.rotation_accumulator[15], state_cur.rotation_accumulator}
          + {{12{step[4]}}, step};
      if (sum > $signed({TOTAL_MAX[15], TOTAL_MAX})) begin
         acc_next = TOTAL_MAX;
      end else if (sum < $signed({TOTAL_MIN[15], TOTAL_MIN})) begin
         acc_next = TOTAL_MIN;
      end else begin
         acc_next = sum[15:0];
      end

      state_next = state_cur;
      result     = '0;

      if (item.command == CMD_READ) begin
         state_next.rotation_accumulator = '0;
         result.rotation_total           = state_cur.rotation_accumulator;
      end else begin
         state_next.pin_history        = pin_next;
         state_next.transition_history = trans_next;
         if (detent) begin
            state_next.last_detent_time     = item.now_ms;
            state_next.rotation_accumulator = acc_next;
            result.step                     = step;
            result.step_valid               = 1'b1;
         end
         result.rotation_total = state_next.rotation_accumulator;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/quadrature_decoder_with_acceleration.sv
// ----------------------------------------------------------------------------
// Quadrature decoder with acceleration
// Decodes rotary encoder pin samples into detents, scales them by speed and
// keeps a saturating rotation total that a read command returns and clears.
// ----------------------------------------------------------------------------
// Requests pass through the request register and then the result register.
// Throughput: one request per cycle unless the sink stalls; the decode, the
// elapsed-time compare and the saturating add all fit between the registers.
// Reset clears the decoder state and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_with_acceleration
   import qdec_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   qdec_stream_if.sink   req_ch,
   qdec_stream_if.source rsp_ch,
   input  wire         csr_write_enable,
   input  wire [1:0]   csr_index,
   input  wire [15:0]  csr_write_data
);

   // Request register: holds one accepted item until the result slot frees.
   logic         in_valid_ff;
   req_item_type in_item_ff;

   // Result register: holds one finished result until the sink takes it.
   logic         out_valid_ff;
   rsp_item_type out_item_ff;

   cfg_type      cfg_ff;
   state_type    state_ff;
   state_type    state_in;
   rsp_item_type result_in;

   logic out_free;
   logic advance;

   // An item moves from the request register into the result register when
   // the result slot is empty or its result is being transferred out now.
   // The decoder state advances exactly with that move, so items update it
   // in their arrival order.
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || advance;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_item_ff;

   qdec_step u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff.fast_threshold_ms   <= FAST_THRESHOLD_RESET;
         cfg_ff.medium_threshold_ms <= MEDIUM_THRESHOLD_RESET;
         cfg_ff.fast_gain           <= FAST_GAIN_RESET;
         cfg_ff.medium_gain         <= MEDIUM_GAIN_RESET;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end

         // Write configuration only while no item is in flight (not enforced).
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_FAST_THRESHOLD:   cfg_ff.fast_threshold_ms   <= csr_write_data;
               CSR_MEDIUM_THRESHOLD: cfg_ff.medium_threshold_ms <= csr_write_data;
               CSR_FAST_GAIN:        cfg_ff.fast_gain           <= csr_write_data[3:0];
               CSR_MEDIUM_GAIN:      cfg_ff.medium_gain         <= csr_write_data[3:0];
               default:              cfg_ff.fast_gain           <= cfg_ff.fast_gain;
            endcase
         end
      end
   end

   // Payload registers carry no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff <= req_ch.payload;
      end
      if (advance) begin
         out_item_ff <= result_in;
      end
   end

   // A read command leaves the accumulator at zero.
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.command == CMD_READ |=> state_ff.rotation_accumulator == '0)
      else $error("accumulator not cleared by read");

   // The accumulator only changes when an item passes into the result register.
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff.rotation_accumulator))
      else $error("accumulator changed without an item");

   // The detent time only moves on a sample that completed a detent.
   a_detent_time: assert property (@(posedge clock) disable iff (reset)
      advance && !result_in.step_valid |=> $stable(state_ff.last_detent_time))
      else $error("detent time changed without a detent");

   // A waiting request is held while the result slot is blocked.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_item_ff))
      else $error("request lost while result blocked");

   // A result without a detent carries a zero step.
   a_zero_step: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.step_valid |-> out_item_ff.step == '0)
      else $error("nonzero step without detent");

endmodule

`default_nettype wire
